/* src/mlfs_pkg.sv */
package mlfs_pkg;

	localparam int PROCS        = 16;
	localparam int QUEUES       = 7;
	localparam int READY_QUEUES = 5;
	localparam int IPROCS       = 4;

	localparam int PW = (PROCS > 1) ? $clog2(PROCS) : 1;
	localparam int KW = $clog2(PROCS + 1);
	localparam int QW = 3;

	localparam logic [QW-1:0] Q_BLK_MEM  = QW'(5);
	localparam logic [QW-1:0] Q_BLK_RECV = QW'(6);
	localparam logic [2:0]    NULL_PRIO  = 3'd4;

	localparam logic [2:0] REQ_ENQ   = 3'd0;
	localparam logic [2:0] REQ_REM   = 3'd1;
	localparam logic [2:0] REQ_SCHED = 3'd2;
	localparam logic [2:0] REQ_UNBLK = 3'd3;
	localparam logic [2:0] REQ_SETP  = 3'd4;
	localparam logic [2:0] REQ_GETP  = 3'd5;

	localparam logic [1:0] PST_READY = 2'd0;
	localparam logic [1:0] PST_MEM   = 2'd1;
	localparam logic [1:0] PST_RECV  = 2'd2;
	localparam logic [1:0] PST_OTHER = 2'd3;

	localparam logic [3:0] ST_OK           = 4'd0;
	localparam logic [3:0] ST_ERR          = 4'd1;
	localparam logic [3:0] ST_NOPID        = 4'd2;
	localparam logic [3:0] ST_BADSTATE     = 4'd3;
	localparam logic [3:0] ST_NOTBLOCKED   = 4'd4;
	localparam logic [3:0] ST_EMPTY        = 4'd5;
	localparam logic [3:0] ST_NULLFIXED    = 4'd6;
	localparam logic [3:0] ST_NULLRESERVED = 4'd7;
	localparam logic [3:0] ST_NOPRIO       = 4'd8;

	typedef struct packed {
		logic       load;
		logic       q_zero;
		logic       q_inc;
		logic       q_sched;
		logic       q_blk;
		logic       k_zero;
		logic       k_inc;
		logic       rd;
		logic       push;
		logic       push_rd;
		logic       shift_wr;
		logic       cnt_dec;
		logic       cnt_clr;
		logic       prio_wr;
		logic       cap_pid;
		logic       out_load;
		logic [3:0] out_status;
		logic       out_pid;
		logic       out_prio;
		logic       out_rel;
	} cmd_t;

	typedef struct packed {
		logic [2:0] req;
		logic [1:0] st;
		logic       cur;
		logic       intr;
		logic       known;
		logic       null_fixed;
		logic       null_res;
		logic       prio_bad;
		logic       qsel_ok;
		logic       ready_empty;
		logic       k_end;
		logic       q_last;
		logic       match;
		logic       full;
	} sts_t;

endpackage

/* src/mlfs_datapath.sv */
module mlfs_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  mlfs_pkg::cmd_t      cmd,
	output mlfs_pkg::sts_t      sts,
	input  logic [23:0]         s_axis_tdata,
	output logic [15:0]         m_axis_tdata
);
	import mlfs_pkg::*;

	logic [PW-1:0] mem [QUEUES][PROCS];
	logic [KW-1:0] cnt_q [QUEUES];
	logic [2:0]    tbl_q [PROCS];

	logic [2:0]        req_q;
	logic signed [4:0] pid_q;
	logic [1:0]        st_q;
	logic signed [3:0] prio_q;
	logic [2:0]        qsel_q;
	logic              cur_q;

	logic [QW-1:0] q_q;
	logic [KW-1:0] k_q;
	logic [PW-1:0] rdata_s1;
	logic [PW-1:0] pidres_q;
	logic [15:0]   out_q;

	logic [PW-1:0] pid_idx, tbl_idx, push_id, km1;
	logic [2:0]    tbl_rd;
	logic [QW-1:0] enq_q, push_q, sched_q;
	logic          ready_empty, full, do_push, cnt_ok;

	assign pid_idx = PW'(pid_q[3:0]);
	assign tbl_idx = cmd.push_rd ? rdata_s1 : pid_idx;
	assign tbl_rd  = tbl_q[tbl_idx];
	assign push_id = cmd.push_rd ? rdata_s1 : pid_idx;
	assign km1     = PW'(k_q - KW'(1));

	always_comb begin
		unique case (st_q)
			PST_READY: enq_q = QW'(tbl_rd);
			PST_MEM:   enq_q = Q_BLK_MEM;
			PST_RECV:  enq_q = Q_BLK_RECV;
			default:   enq_q = '0;
		endcase
	end

	assign push_q  = cmd.push_rd ? QW'(tbl_rd) : enq_q;
	assign full    = (cnt_q[push_q] == KW'(PROCS));
	assign do_push = cmd.push && !full;

	always_comb begin
		sched_q     = '0;
		ready_empty = 1'b1;
		for (int i = READY_QUEUES - 1; i >= 0; i--) begin
			if (cnt_q[i] != '0) begin
				sched_q     = QW'(i);
				ready_empty = 1'b0;
			end
		end
	end

	always_comb begin
		sts.req         = req_q;
		sts.st          = st_q;
		sts.cur         = cur_q;
		sts.intr        = (int'(pid_q) < 0) && (int'(pid_q) >= -IPROCS);
		sts.known       = !pid_q[4] && (int'(pid_q) < PROCS);
		sts.null_fixed  = (pid_q == 5'sd0) && (prio_q != 4'sd4);
		sts.null_res    = (pid_q != 5'sd0) && (prio_q == 4'sd4);
		sts.prio_bad    = (prio_q < 4'sd0) || (prio_q > 4'sd4);
		sts.qsel_ok     = (qsel_q == Q_BLK_MEM) || (qsel_q == Q_BLK_RECV);
		sts.ready_empty = ready_empty;
		sts.k_end       = (k_q == cnt_q[q_q]);
		sts.q_last      = (q_q == QW'(QUEUES - 1));
		sts.match       = sts.known && (rdata_s1 == pid_idx);
		sts.full        = full;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= s_axis_tdata[2:0];
			pid_q  <= s_axis_tdata[7:3];
			st_q   <= s_axis_tdata[9:8];
			prio_q <= s_axis_tdata[13:10];
			qsel_q <= s_axis_tdata[16:14];
			cur_q  <= s_axis_tdata[17];
		end
		if (cmd.rd)
			rdata_s1 <= mem[q_q][k_q[PW-1:0]];
		if (do_push)
			mem[push_q][cnt_q[push_q][PW-1:0]] <= push_id;
		else if (cmd.shift_wr)
			mem[q_q][km1] <= rdata_s1;
		if (cmd.cap_pid)
			pidres_q <= rdata_s1;
		if (cmd.out_load)
			out_q <= {4'b0, cmd.out_rel,
				cmd.out_prio ? tbl_rd : 3'd0,
				cmd.out_pid ? 4'(pidres_q) : 4'd0,
				cmd.out_status};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_q <= '0;
			k_q <= '0;
			for (int i = 0; i < QUEUES; i++)
				cnt_q[i] <= '0;
			for (int i = 0; i < PROCS; i++)
				tbl_q[i] <= (i == 0) ? NULL_PRIO : 3'd3;
		end else begin
			if (cmd.q_zero)
				q_q <= '0;
			else if (cmd.q_inc)
				q_q <= q_q + QW'(1);
			else if (cmd.q_sched)
				q_q <= sched_q;
			else if (cmd.q_blk)
				q_q <= qsel_q;
			if (cmd.k_zero)
				k_q <= '0;
			else if (cmd.k_inc)
				k_q <= k_q + KW'(1);
			for (int i = 0; i < QUEUES; i++) begin
				if (do_push && push_q == QW'(i))
					cnt_q[i] <= cnt_q[i] + KW'(1);
				else if (cmd.cnt_dec && q_q == QW'(i))
					cnt_q[i] <= cnt_q[i] - KW'(1);
				else if (cmd.cnt_clr && q_q == QW'(i))
					cnt_q[i] <= '0;
			end
			if (cmd.prio_wr)
				tbl_q[pid_idx] <= prio_q[2:0];
		end
	end

	assign m_axis_tdata = out_q;

	always_comb begin
		cnt_ok = 1'b1;
		for (int i = 0; i < QUEUES; i++)
			if (cnt_q[i] > KW'(PROCS))
				cnt_ok = 1'b0;
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_ok)
		else $error("queue count beyond depth");
	a_shift_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_wr |-> (k_q != '0))
		else $error("shift write at head slot");
	a_push_known: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && !cmd.push_rd) |-> (sts.known && st_q != PST_OTHER))
		else $error("push of unknown pid");
	a_dec_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> (cnt_q[q_q] != '0))
		else $error("drop from empty queue");

endmodule

/* src/mlfs_ctrl.sv */
module mlfs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	input  mlfs_pkg::sts_t sts,
	output mlfs_pkg::cmd_t cmd
);
	import mlfs_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_CHK  = 4'd2;
	localparam logic [3:0] S_CMP  = 4'd3;
	localparam logic [3:0] S_SHF  = 4'd4;
	localparam logic [3:0] S_SHW  = 4'd5;
	localparam logic [3:0] S_SRD  = 4'd6;
	localparam logic [3:0] S_SCAP = 4'd7;
	localparam logic [3:0] S_UNB  = 4'd8;
	localparam logic [3:0] S_UNBP = 4'd9;
	localparam logic [3:0] S_REQ  = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [3:0] state_q, nxt;
	logic [3:0] stat_q, fst;
	logic       pidf_q, prf_q, rel_q, fpid, fpr, frel, fin, mv_q;
	logic       done, found;

	always_comb begin
		cmd   = '0;
		nxt   = state_q;
		fin   = 1'b0;
		fst   = ST_OK;
		fpid  = 1'b0;
		fpr   = 1'b0;
		frel  = 1'b0;
		done  = 1'b0;
		found = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					cmd.load   = 1'b1;
					cmd.q_zero = 1'b1;
					cmd.k_zero = 1'b1;
					nxt        = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.req)
					REQ_ENQ: begin
						fin = 1'b1;
						if (sts.intr)
							fst = ST_OK;
						else if (!sts.known)
							fst = ST_NOPID;
						else if (sts.st == PST_OTHER)
							fst = ST_BADSTATE;
						else if (sts.full)
							fst = ST_ERR;
						else
							cmd.push = 1'b1;
					end
					REQ_REM: nxt = S_CHK;
					REQ_SCHED: begin
						if (sts.ready_empty) begin
							fin = 1'b1;
							fst = ST_EMPTY;
						end else begin
							cmd.q_sched = 1'b1;
							nxt         = S_SRD;
						end
					end
					REQ_UNBLK: begin
						if (!sts.qsel_ok) begin
							fin = 1'b1;
							fst = ST_NOTBLOCKED;
						end else begin
							cmd.q_blk = 1'b1;
							nxt       = S_UNB;
						end
					end
					REQ_SETP: begin
						if (sts.null_fixed) begin
							fin = 1'b1;
							fst = ST_NULLFIXED;
						end else if (sts.null_res) begin
							fin = 1'b1;
							fst = ST_NULLRESERVED;
						end else if (sts.prio_bad) begin
							fin = 1'b1;
							fst = ST_NOPRIO;
						end else if (!sts.known) begin
							fin = 1'b1;
							fst = ST_NOPID;
						end else begin
							cmd.prio_wr = 1'b1;
							if (sts.cur) begin
								fin  = 1'b1;
								frel = 1'b1;
							end else
								nxt = S_CHK;
						end
					end
					REQ_GETP: begin
						fin = 1'b1;
						if (!sts.known)
							fst = ST_NOPID;
						else
							fpr = 1'b1;
					end
					default: begin
						fin = 1'b1;
						fst = ST_ERR;
					end
				endcase
			end
			S_CHK: begin
				if (sts.k_end) begin
					if (sts.q_last)
						done = 1'b1;
					else begin
						cmd.q_inc  = 1'b1;
						cmd.k_zero = 1'b1;
					end
				end else begin
					cmd.rd = 1'b1;
					nxt    = S_CMP;
				end
			end
			S_CMP: begin
				cmd.k_inc = 1'b1;
				nxt       = sts.match ? S_SHF : S_CHK;
			end
			S_SHF: begin
				if (sts.k_end) begin
					cmd.cnt_dec = 1'b1;
					done        = 1'b1;
					found       = 1'b1;
				end else begin
					cmd.rd = 1'b1;
					nxt    = S_SHW;
				end
			end
			S_SHW: begin
				cmd.shift_wr = 1'b1;
				cmd.k_inc    = 1'b1;
				nxt          = S_SHF;
			end
			S_SRD: begin
				cmd.rd = 1'b1;
				nxt    = S_SCAP;
			end
			S_SCAP: begin
				cmd.cap_pid = 1'b1;
				cmd.k_inc   = 1'b1;
				nxt         = S_SHF;
			end
			S_UNB: begin
				if (sts.k_end) begin
					cmd.cnt_clr = 1'b1;
					fin         = 1'b1;
				end else begin
					cmd.rd = 1'b1;
					nxt    = S_UNBP;
				end
			end
			S_UNBP: begin
				cmd.push    = 1'b1;
				cmd.push_rd = 1'b1;
				cmd.k_inc   = 1'b1;
				nxt         = S_UNB;
			end
			S_REQ: begin
				if (sts.st != PST_OTHER)
					cmd.push = 1'b1;
				fin  = 1'b1;
				frel = 1'b1;
			end
			S_FIN: begin
				if (!mv_q || m_axis_tready) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = stat_q;
					cmd.out_pid    = pidf_q;
					cmd.out_prio   = prf_q;
					cmd.out_rel    = rel_q;
					nxt            = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
		if (done) begin
			unique case (sts.req)
				REQ_REM: begin
					fin = 1'b1;
					fst = found ? ST_OK : ST_ERR;
				end
				REQ_SCHED: begin
					fin  = 1'b1;
					fpid = 1'b1;
				end
				default: nxt = S_REQ;
			endcase
		end
		if (fin)
			nxt = S_FIN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= ST_OK;
			pidf_q  <= 1'b0;
			prf_q   <= 1'b0;
			rel_q   <= 1'b0;
			mv_q    <= 1'b0;
		end else begin
			state_q <= nxt;
			if (fin) begin
				stat_q <= fst;
				pidf_q <= fpid;
				prf_q  <= fpr;
				rel_q  <= frel;
			end
			if (cmd.out_load)
				mv_q <= 1'b1;
			else if (m_axis_tready)
				mv_q <= 1'b0;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = mv_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!mv_q || m_axis_tready))
		else $error("result overwritten before taken");
	a_fin_next: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> (state_q == S_FIN))
		else $error("finish did not reach result state");
	a_one_src: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.q_zero, cmd.q_inc, cmd.q_sched, cmd.q_blk}))
		else $error("conflicting queue index commands");

endmodule

/* src/multilevel_fifo_process_scheduler.sv */
// Enqueue, get priority and rejected requests finish in the dispatch state; remove and
// set priority of a process that is not current walk the queues slot by slot and queue
// by queue, and the shift after a match moves each later slot of that queue down by
// one; unblock moves each slot of the blocked queue to its ready queue in turn.
// Throughput: one request at a time; the single-port slot memory sets the pace.
// Reset: all queues empty, priority 4 for process 0 and 3 for the rest.
module multilevel_fifo_process_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// req_type[2:0], pid[7:3], proc_state[9:8], new_priority[13:10],
	// queue_sel[16:14], is_current[17]
	input  logic [23:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[3:0], pid_out[7:4], priority_out[10:8], release_request[11]
	output logic [15:0] m_axis_tdata
);
	import mlfs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	mlfs_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.sts           (sts),
		.cmd           (cmd)
	);

	mlfs_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule
